### rtl/core/rdfu_pkg.sv
// Package for the RGBA delta filter undo block: register map, modes and widths.
`timescale 1ns / 1ps
`default_nettype none

package rdfu_pkg;

    localparam int PixelWidth = 32;
    localparam int DimWidth   = 16;
    localparam int AddrWidth  = 32;
    localparam int CfgIdxWidth = 3;
    localparam int CfgDataWidth = 32;

    typedef logic [PixelWidth-1:0]   t_pixel;
    typedef logic [DimWidth-1:0]     t_dim;
    typedef logic [AddrWidth-1:0]    t_addr;
    typedef logic [CfgIdxWidth-1:0]  t_cfg_idx;
    typedef logic [1:0]              t_mode;

    // Configuration register indexes
    localparam t_cfg_idx CfgFilterMode   = 3'd0;
    localparam t_cfg_idx CfgAlphaEnabled = 3'd1;
    localparam t_cfg_idx CfgImageWidth   = 3'd2;
    localparam t_cfg_idx CfgImageHeight  = 3'd3;
    localparam t_cfg_idx CfgStartValue   = 3'd4;

    // Filter modes; the unused code behaves as ModeNone
    localparam t_mode ModeNone = 2'd0;
    localparam t_mode ModeSub  = 2'd1;
    localparam t_mode ModeUp   = 2'd2;

    localparam t_pixel StartValueReset = 32'h0000_00FF;
    localparam logic [7:0] AlphaOpaque = 8'hFF;

    typedef struct packed {
        t_pixel pixel;
        t_addr  addr;
        logic   last;
    } t_result;

    // Per-byte add modulo 256; alpha forced opaque unless accumulated.
    function automatic t_pixel add_bytes(input t_pixel prev, input t_pixel cur,
                                         input logic with_alpha);
        t_pixel res;
        res[31:24] = prev[31:24] + cur[31:24];
        res[23:16] = prev[23:16] + cur[23:16];
        res[15:8]  = prev[15:8]  + cur[15:8];
        res[7:0]   = with_alpha ? (prev[7:0] + cur[7:0]) : AlphaOpaque;
        return res;
    endfunction

endpackage

`default_nettype wire

### rtl/core/rgba_delta_filter_undo.sv
// Top level of the RGBA delta filter undo: pixel restore, position counters, result skid.
//
//  channel   | direction | handshake                       | payload
//  ----------+-----------+---------------------------------+-------------------------------
//  pixel in  | in        | i_pixel_valid / o_pixel_stall   | i_pixel_in
//  result    | out       | o_result_valid / i_result_stall | o_pixel_out, o_store_address,
//            |           |                                 | o_last_pixel
//  config    | in        | i_cfg_valid / o_cfg_ready       | i_cfg_index, i_cfg_data
//
// One pixel per clock while o_pixel_stall is low; o_pixel_out and its address are registered.
// The byte adders, the 16x16 address multiply and the counters sit between the
// state registers and the result register.
// A two-entry result buffer (output register plus skid) keeps input beats flowing
// while the result side stalls; o_pixel_stall rises when both entries are full or in reset.
// Synchronous active-low reset; stall is held and cfg ready low during reset.
`timescale 1ns / 1ps
`default_nettype none

module rgba_delta_filter_undo
    import rdfu_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,

    input  wire logic                    i_pixel_valid,
    output      logic                    o_pixel_stall,
    input  wire logic [PixelWidth-1:0]   i_pixel_in,

    output      logic                    o_result_valid,
    input  wire logic                    i_result_stall,
    output      logic [PixelWidth-1:0]   o_pixel_out,
    output      logic [AddrWidth-1:0]    o_store_address,
    output      logic                    o_last_pixel,

    input  wire logic                    i_cfg_valid,
    output      logic                    o_cfg_ready,
    input  wire logic [CfgIdxWidth-1:0]  i_cfg_index,
    input  wire logic [CfgDataWidth-1:0] i_cfg_data
);

    // Configuration registers
    t_mode  r_filter_mode;
    logic   r_alpha_enabled;
    t_dim   r_image_width;
    t_dim   r_image_height;
    t_pixel r_start_value;

    // Walk state
    t_pixel r_running;
    t_dim   r_row;
    t_dim   r_col;
    logic   r_first;
    logic   r_ready;

    // Result buffer
    t_result r_out;
    t_result r_skid;
    logic    r_out_valid;
    logic    r_skid_valid;

    t_dim    w_eff;
    t_dim    h_eff;
    logic    row_end;
    logic    col_end;
    logic    last;
    logic    filtering;
    t_pixel  prev;
    t_pixel  restored;
    t_result res;
    logic    in_fire;
    logic    out_fire;
    logic    cfg_fire;
    t_dim    n_row;
    t_dim    n_col;
    logic    n_first;

    assign cfg_fire = i_cfg_valid && o_cfg_ready;
    assign in_fire  = i_pixel_valid && !o_pixel_stall;
    assign out_fire = r_out_valid && !i_result_stall;

    assign o_cfg_ready     = r_ready;
    assign o_pixel_stall   = r_skid_valid || !r_ready;
    assign o_result_valid  = r_out_valid;
    assign o_pixel_out     = r_out.pixel;
    assign o_store_address = r_out.addr;
    assign o_last_pixel    = r_out.last;

    always_comb begin
        w_eff = (r_image_width  == '0) ? t_dim'(1) : r_image_width;
        h_eff = (r_image_height == '0) ? t_dim'(1) : r_image_height;
        row_end = r_row >= (h_eff - t_dim'(1));
        col_end = r_col >= (w_eff - t_dim'(1));
        last = row_end && col_end;
        filtering = (r_filter_mode == ModeSub) || (r_filter_mode == ModeUp);
        prev = r_first ? r_start_value : r_running;
        restored = filtering ? add_bytes(prev, i_pixel_in, r_alpha_enabled) : i_pixel_in;

        res.pixel = restored;
        // max 65535*65535 + 65535 still fits in 32 bits
        res.addr  = t_addr'(w_eff) * t_addr'(r_row) + t_addr'(r_col);
        res.last  = last;

        n_row   = r_row;
        n_col   = r_col;
        n_first = 1'b0;
        if (last) begin
            n_row   = '0;
            n_col   = '0;
            n_first = 1'b1;
        end else if (r_filter_mode == ModeUp) begin
            if (row_end) begin
                n_row = '0;
                n_col = r_col + t_dim'(1);
            end else begin
                n_row = r_row + t_dim'(1);
            end
        end else begin
            if (col_end) begin
                n_col = '0;
                n_row = r_row + t_dim'(1);
            end else begin
                n_col = r_col + t_dim'(1);
            end
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_mode   <= ModeNone;
            r_alpha_enabled <= 1'b0;
            r_image_width   <= t_dim'(1);
            r_image_height  <= t_dim'(1);
            r_start_value   <= StartValueReset;
            r_ready         <= 1'b0;
        end else begin
            r_ready <= 1'b1;
            if (cfg_fire) begin
                case (i_cfg_index)
                    CfgFilterMode:   r_filter_mode   <= i_cfg_data[1:0];
                    CfgAlphaEnabled: r_alpha_enabled <= i_cfg_data[0];
                    CfgImageWidth:   r_image_width   <= i_cfg_data[DimWidth-1:0];
                    CfgImageHeight:  r_image_height  <= i_cfg_data[DimWidth-1:0];
                    CfgStartValue:   r_start_value   <= i_cfg_data[PixelWidth-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Position and first-pixel flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row   <= '0;
            r_col   <= '0;
            r_first <= 1'b1;
        end else if (in_fire) begin
            r_row   <= n_row;
            r_col   <= n_col;
            r_first <= n_first;
        end
    end

    // Seen mid-image when filtering starts after pass-through pixels
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running <= StartValueReset;
        end else if (in_fire && filtering) begin
            r_running <= restored;
        end
    end

    // Result register and skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_fire) begin
                r_skid_valid <= 1'b0;
            end
        end else if (in_fire) begin
            if (r_out_valid && !out_fire) begin
                r_skid_valid <= 1'b1;
            end
            r_out_valid <= 1'b1;
        end else if (out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_fire) begin
                r_out <= r_skid;
            end
        end else if (in_fire) begin
            if (r_out_valid && !out_fire) begin
                r_skid <= res;
            end else begin
                r_out <= res;
            end
        end
    end

    // The skid entry only fills behind a held output beat
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry valid without output beat");

    // A stalled output beat is never dropped
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_result_stall) |=> r_out_valid)
        else $error("stalled result beat lost");

    // The pixel marked last starts a new image
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && last) |=> (r_first && r_row == '0 && r_col == '0))
        else $error("image end did not rewind position");

    // A pixel that is not last leaves the first-pixel flag clear
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && !last) |=> !r_first)
        else $error("first-pixel flag set mid-image");

endmodule

`default_nettype wire
